// ===== design/strs_pkg.sv =====
// ----------------------------------------------------------------------------
// Segment tree range sum package
// Field widths, stream layout, function codes and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package strs_pkg;

    localparam int LEAVES_DEFAULT = 1024;

    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int BOUND_W = 11;
    localparam int SUM_W   = 42;

    localparam int IDX_LSB = 0;
    localparam int VAL_LSB = IDX_LSB + IDX_W;
    localparam int LO_LSB  = VAL_LSB + VAL_W;
    localparam int HI_LSB  = LO_LSB + BOUND_W;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 48;

    localparam logic FUNC_SET   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic clr_step;
        logic load_item;
        logic upd_leaf;
        logic upd_read;
        logic upd_sum;
        logic q_read_l;
        logic q_read_r;
        logic q_acc;
        logic q_shift;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic idx_ok;
        logic parent_is_root;
        logic l_lt_r;
        logic l_odd;
        logic r_odd;
    } status_t;

endpackage

// ===== design/segment_tree_range_sum.sv =====
// Update: the leaf is written, then each level reads the sibling and writes the parent sum.
// Query: the single read port of the node memory sets the pace, with one node read
// and one accumulate step per boundary node.
// One item is in work at a time; a finished result waits in the output register.
// After reset the node memory is cleared with s_axis_tready low.
// ----------------------------------------------------------------------------
// Segment tree range sum
// Point update and half-open range sum over a power-of-two number of leaves.
// ----------------------------------------------------------------------------
module segment_tree_range_sum #(
    parameter int LEAVES = strs_pkg::LEAVES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // leaf_index, leaf_value, range_lo, range_hi
    input  logic [strs_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // func
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // range_sum, zero padding
    output logic [strs_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    strs_pkg::cmd_t             cmd;
    strs_pkg::status_t          status;
    logic [strs_pkg::SUM_W-1:0] result;

    strs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_func   (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    strs_dp #(
        .LEAVES (LEAVES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_data (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    assign m_axis_tdata = strs_pkg::M_TDATA_W'(result);

endmodule

// ===== design/strs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module strs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== design/strs_dp.sv =====
// ----------------------------------------------------------------------------
// Segment tree datapath
// Node memory in one-based heap order, position registers for the update
// climb and the query walk, the accumulator and the result register.
// ----------------------------------------------------------------------------
module strs_dp #(
    parameter int LEAVES = strs_pkg::LEAVES_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [strs_pkg::S_TDATA_W-1:0] item_data,
    input  strs_pkg::cmd_t                 cmd,
    output strs_pkg::status_t              status,
    output logic [strs_pkg::SUM_W-1:0]     result
);

    localparam int LW = $clog2(LEAVES);
    localparam int AW = LW + 1;
    localparam int PW = LW + 2;
    localparam int CW = (PW > strs_pkg::BOUND_W) ? PW : strs_pkg::BOUND_W;
    localparam logic [CW-1:0] LEAVES_C = CW'(LEAVES);
    localparam logic [PW-1:0] LEAVES_P = PW'(LEAVES);

    logic [strs_pkg::IDX_W-1:0]   idx;
    logic [strs_pkg::VAL_W-1:0]   value;
    logic [strs_pkg::BOUND_W-1:0] lo;
    logic [strs_pkg::BOUND_W-1:0] hi;
    logic [CW-1:0]                idx_ext;
    logic [CW-1:0]                lo_ext;
    logic [CW-1:0]                hi_ext;
    logic [CW-1:0]                lo_sat;
    logic [CW-1:0]                hi_sat;
    logic [strs_pkg::SUM_W-1:0]   value_ext;

    logic [PW-1:0]              p_reg;
    logic [PW-1:0]              l_reg;
    logic [PW-1:0]              r_reg;
    logic [PW-1:0]              r_dec;
    logic [PW-1:0]              parent;
    logic [strs_pkg::SUM_W-1:0] cur_reg;
    logic [strs_pkg::SUM_W-1:0] acc_reg;
    logic [strs_pkg::SUM_W-1:0] result_reg;
    logic [strs_pkg::SUM_W-1:0] upd_sum;
    logic [AW-1:0]              clr_cnt_reg;

    logic                       we;
    logic [AW-1:0]              waddr;
    logic [strs_pkg::SUM_W-1:0] wdata;
    logic [AW-1:0]              raddr;
    logic [strs_pkg::SUM_W-1:0] rdata;

    assign idx   = item_data[strs_pkg::IDX_LSB +: strs_pkg::IDX_W];
    assign value = item_data[strs_pkg::VAL_LSB +: strs_pkg::VAL_W];
    assign lo    = item_data[strs_pkg::LO_LSB +: strs_pkg::BOUND_W];
    assign hi    = item_data[strs_pkg::HI_LSB +: strs_pkg::BOUND_W];

    assign idx_ext   = CW'(idx);
    assign lo_ext    = CW'(lo);
    assign hi_ext    = CW'(hi);
    assign lo_sat    = (lo_ext > LEAVES_C) ? LEAVES_C : lo_ext;
    assign hi_sat    = (hi_ext > LEAVES_C) ? LEAVES_C : hi_ext;
    assign value_ext = {{(strs_pkg::SUM_W - strs_pkg::VAL_W){value[strs_pkg::VAL_W-1]}},
                        value};

    assign r_dec   = r_reg - PW'(1);
    assign parent  = p_reg >> 1;
    assign upd_sum = cur_reg + rdata;

    always_comb
    begin
        we    = 1'b0;
        waddr = clr_cnt_reg;
        wdata = '0;
        if (cmd.upd_leaf)
        begin
            we    = 1'b1;
            waddr = p_reg[AW-1:0];
            wdata = cur_reg;
        end
        else if (cmd.upd_sum)
        begin
            we    = 1'b1;
            waddr = parent[AW-1:0];
            wdata = upd_sum;
        end
        else if (cmd.clr_step)
        begin
            we = 1'b1;
        end
    end

    always_comb
    begin
        if (cmd.q_read_l)
        begin
            raddr = l_reg[AW-1:0];
        end
        else if (cmd.q_read_r)
        begin
            raddr = r_dec[AW-1:0];
        end
        else if (cmd.upd_read)
        begin
            raddr = p_reg[AW-1:0] ^ AW'(1);
        end
        else
        begin
            raddr = '0;
        end
    end

    strs_ram #(
        .WIDTH (strs_pkg::SUM_W),
        .DEPTH (2 * LEAVES)
    ) u_node_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            p_reg   <= PW'(idx_ext) + LEAVES_P;
            l_reg   <= PW'(lo_sat) + LEAVES_P;
            r_reg   <= PW'(hi_sat) + LEAVES_P;
            cur_reg <= value_ext;
            acc_reg <= '0;
        end
        else
        begin
            if (cmd.upd_sum)
            begin
                p_reg   <= parent;
                cur_reg <= upd_sum;
            end
            if (cmd.q_acc)
            begin
                acc_reg <= acc_reg + rdata;
            end
            if (cmd.q_read_l)
            begin
                l_reg <= l_reg + PW'(1);
            end
            if (cmd.q_read_r)
            begin
                r_reg <= r_dec;
            end
            if (cmd.q_shift)
            begin
                l_reg <= l_reg >> 1;
                r_reg <= r_reg >> 1;
            end
        end
        if (cmd.load_out)
        begin
            result_reg <= acc_reg;
        end
    end

    assign status.clr_done       = &clr_cnt_reg;
    assign status.idx_ok         = idx_ext < LEAVES_C;
    assign status.parent_is_root = parent == PW'(1);
    assign status.l_lt_r         = l_reg < r_reg;
    assign status.l_odd          = l_reg[0];
    assign status.r_odd          = r_reg[0];

    assign result = result_reg;

endmodule

// ===== design/strs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Segment tree controller
// Sequences the clearing pass, the update climb and the query walk, and
// owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module strs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_func,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  strs_pkg::status_t status,
    output strs_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD_LEAF,
        S_UPD_READ,
        S_UPD_SUM,
        S_Q_TEST,
        S_Q_ACCL,
        S_Q_ACCR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (in_func == strs_pkg::FUNC_QUERY)
                    begin
                        state_next = S_Q_TEST;
                    end
                    else if (status.idx_ok)
                    begin
                        state_next = S_UPD_LEAF;
                    end
                end
            end
            S_UPD_LEAF:
            begin
                cmd.upd_leaf = 1'b1;
                state_next   = S_UPD_READ;
            end
            S_UPD_READ:
            begin
                cmd.upd_read = 1'b1;
                state_next   = S_UPD_SUM;
            end
            S_UPD_SUM:
            begin
                cmd.upd_sum = 1'b1;
                state_next  = status.parent_is_root ? S_IDLE : S_UPD_READ;
            end
            S_Q_TEST:
            begin
                if (status.l_lt_r)
                begin
                    if (status.l_odd)
                    begin
                        cmd.q_read_l = 1'b1;
                        state_next   = S_Q_ACCL;
                    end
                    else if (status.r_odd)
                    begin
                        cmd.q_read_r = 1'b1;
                        state_next   = S_Q_ACCR;
                    end
                    else
                    begin
                        cmd.q_shift = 1'b1;
                    end
                end
                else if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_Q_ACCL:
            begin
                cmd.q_acc = 1'b1;
                if (status.r_odd)
                begin
                    cmd.q_read_r = 1'b1;
                    state_next   = S_Q_ACCR;
                end
                else
                begin
                    cmd.q_shift = 1'b1;
                    state_next  = S_Q_TEST;
                end
            end
            S_Q_ACCR:
            begin
                cmd.q_acc   = 1'b1;
                cmd.q_shift = 1'b1;
                state_next  = S_Q_TEST;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

// ===== design/strs_checker.sv =====
// ----------------------------------------------------------------------------
// Segment tree range sum checker
// Port-level checks of reset, sequencing, result hold behavior and result padding.
// ----------------------------------------------------------------------------
module strs_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [strs_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    logic query_accept;

    assign query_accept = s_axis_tvalid && s_axis_tready
                          && (s_axis_tuser == strs_pkg::FUNC_QUERY);

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !s_axis_tready && !m_axis_tvalid)
        else $error("Ports not quiet during reset.");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        query_accept |=> !s_axis_tready && !$rose(m_axis_tvalid))
        else $error("Query transaction not held for its walk.");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result transaction changed.");

    a_result_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[strs_pkg::M_TDATA_W-1:strs_pkg::SUM_W] == '0)
        else $error("Result padding bits not zero.");

endmodule

bind segment_tree_range_sum strs_checker u_strs_checker (.*);
